FILE: hw/rtl/qwt_pkg.sv
package qwt_pkg;

    localparam int MAX_WORD = 256;
    localparam int CNT_W    = $clog2(MAX_WORD + 1);
    localparam int CHAR_W   = 8;
    localparam int LEN_W    = 9;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_EOL       = 8'd0;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
    localparam logic [CHAR_W-1:0] CH_DQUOTE    = 8'd34;
    localparam logic [CHAR_W-1:0] CH_SQUOTE    = 8'd39;
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'd92;

    typedef enum logic [1:0] {
        PH_BETWEEN = 2'd0,
        PH_WORD    = 2'd1,
        PH_DISCARD = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_WORD_END = 2'd1,
        KIND_LINE_END = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_ESCAPE   = 2'd1,
        ST_TOO_LONG     = 2'd2,
        ST_UNTERMINATED = 2'd3
    } t_status;

    // One queued action: a result, optionally followed by a line end.
    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  word_char;
        t_status            status;
        logic [LEN_W-1:0]   word_length;
        logic               line_end;
    } t_entry;

endpackage

FILE: hw/rtl/quoted_word_tokenizer.sv
// Shell-style word splitter. Feed one byte of a line per transfer on the push
// side (0 ends the line); pop results from the queue-style output. Each byte
// gives zero, one or two results: a word character (kind 0), a word end with
// a status (kind 1: ok, invalid escape, too long, unterminated quote) or a
// line end (kind 2); o_last marks the final result of a byte. A byte is
// classified in the cycle it is taken, so a new byte can be pushed every
// cycle while full is low; results leave one per cycle while pop is high,
// and a byte with two results (a word end closed by the end of line) sends
// both in turn. A four-entry queue between the classifier and the output
// register absorbs bursts and output stalls; full rises only when it is full.
module quoted_word_tokenizer
    import qwt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CHAR_W-1:0] i_character,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        o_kind,
    output logic [CHAR_W-1:0] o_word_char,
    output logic [1:0]        o_status,
    output logic [LEN_W-1:0]  o_word_length,
    output logic              o_last
);

    logic   accept;
    t_entry fr_entry;
    logic   fr_entry_vld;
    t_entry q_entry;
    logic   q_full, q_empty, q_pop;

    // take a byte whenever the queue has room for whatever it produces
    assign full   = q_full;
    assign accept = push && !q_full;

    // front: word/quote/escape state machine, one byte per cycle while the queue has room
    qwt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_character (i_character),
        .o_entry     (fr_entry),
        .o_entry_vld (fr_entry_vld)
    );

    // hold classified actions until the back end can emit them
    qwt_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (fr_entry_vld),
        .i_wr_data (fr_entry),
        .i_rd      (q_pop),
        .o_rd_data (q_entry),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    // back: expand each action into one or two results in the output register
    qwt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (q_entry),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_kind        (o_kind),
        .o_word_char   (o_word_char),
        .o_status      (o_status),
        .o_word_length (o_word_length),
        .o_last        (o_last)
    );

endmodule

FILE: hw/rtl/qwt_front.sv
module qwt_front
    import qwt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [CHAR_W-1:0] i_character,
    output t_entry            o_entry,
    output logic              o_entry_vld
);

    t_phase            r_phase, n_phase;
    logic [CHAR_W-1:0] r_delim, n_delim;
    logic              r_esc, n_esc;
    logic [CNT_W-1:0]  r_count, n_count;

    logic [CNT_W-1:0]  count_inc;
    logic              at_limit;
    logic              is_eol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BETWEEN;
            r_delim <= CH_SPACE;
            r_esc   <= 1'b0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_delim <= n_delim;
            r_esc   <= n_esc;
            r_count <= n_count;
        end
    end

    assign count_inc = CNT_W'(r_count + 1'b1);
    assign at_limit  = (r_count >= CNT_W'(MAX_WORD));
    assign is_eol    = (i_character == CH_EOL);

    always_comb begin
        n_phase     = r_phase;
        n_delim     = r_delim;
        n_esc       = r_esc;
        n_count     = r_count;
        o_entry     = '{kind: KIND_CHAR, word_char: '0, status: ST_OK,
                        word_length: '0, line_end: 1'b0};
        o_entry_vld = 1'b0;

        if (i_accept) begin
            case (r_phase)
                PH_BETWEEN: begin
                    if (is_eol) begin
                        o_entry.kind = KIND_LINE_END;
                        o_entry_vld  = 1'b1;
                    end else if (i_character == CH_SPACE) begin
                        n_phase = PH_BETWEEN;
                    end else if (i_character == CH_DQUOTE ||
                                 i_character == CH_SQUOTE) begin
                        n_delim = i_character;
                        n_count = '0;
                        n_esc   = 1'b0;
                        n_phase = PH_WORD;
                    end else begin
                        n_delim             = CH_SPACE;
                        n_count             = CNT_W'(1);
                        n_esc               = 1'b0;
                        n_phase             = PH_WORD;
                        o_entry.word_char   = i_character;
                        o_entry.word_length = LEN_W'(1);
                        o_entry_vld         = 1'b1;
                    end
                end
                PH_WORD: begin
                    if (at_limit || r_esc) begin
                        n_esc = 1'b0;
                    end
                    if (at_limit && i_character == r_delim) begin
                        o_entry.kind        = KIND_WORD_END;
                        o_entry.word_length = LEN_W'(r_count);
                        o_entry_vld         = 1'b1;
                        n_phase             = PH_BETWEEN;
                    end else if (at_limit || (r_esc && i_character != r_delim &&
                                              i_character != CH_BACKSLASH)) begin
                        // error: end the word, then drop the rest of the line
                        o_entry.kind        = KIND_WORD_END;
                        o_entry.status      = at_limit ? ST_TOO_LONG : ST_BAD_ESCAPE;
                        o_entry.word_length = LEN_W'(r_count);
                        o_entry.line_end    = is_eol;
                        o_entry_vld         = 1'b1;
                        n_phase             = is_eol ? PH_BETWEEN : PH_DISCARD;
                    end else if (r_esc) begin
                        n_count             = count_inc;
                        o_entry.word_char   = i_character;
                        o_entry.word_length = LEN_W'(count_inc);
                        o_entry_vld         = 1'b1;
                    end else if (i_character == r_delim) begin
                        o_entry.kind        = KIND_WORD_END;
                        o_entry.word_length = LEN_W'(r_count);
                        o_entry_vld         = 1'b1;
                        n_phase             = PH_BETWEEN;
                    end else if (is_eol) begin
                        o_entry.kind        = KIND_WORD_END;
                        o_entry.status      = (r_delim == CH_SPACE) ? ST_OK
                                                                    : ST_UNTERMINATED;
                        o_entry.word_length = LEN_W'(r_count);
                        o_entry.line_end    = 1'b1;
                        o_entry_vld         = 1'b1;
                        n_phase             = PH_BETWEEN;
                    end else if (i_character == CH_BACKSLASH) begin
                        n_esc = 1'b1;
                    end else begin
                        n_count             = count_inc;
                        o_entry.word_char   = i_character;
                        o_entry.word_length = LEN_W'(count_inc);
                        o_entry_vld         = 1'b1;
                    end
                end
                PH_DISCARD: begin
                    n_esc = 1'b0;
                    if (is_eol) begin
                        o_entry.kind = KIND_LINE_END;
                        o_entry_vld  = 1'b1;
                        n_phase      = PH_BETWEEN;
                    end
                end
                default: begin
                    n_phase = PH_BETWEEN;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/qwt_queue.sv
module qwt_queue
    import qwt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_entry i_wr_data,
    input  logic   i_rd,
    output t_entry o_rd_data,
    output logic   o_full,
    output logic   o_empty
);

    t_entry           r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0]   r_count;

    logic             do_wr, do_rd;

    assign o_full    = (r_count == QCW'(QDEPTH));
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= QAW'(r_wr_ptr + 1'b1);
            end
            if (do_rd) begin
                r_rd_ptr <= QAW'(r_rd_ptr + 1'b1);
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= QCW'(r_count + 1'b1);
                2'b01:   r_count <= QCW'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/qwt_back.sv
module qwt_back
    import qwt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_entry            i_entry,
    input  logic              i_q_empty,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [1:0]        o_kind,
    output logic [CHAR_W-1:0] o_word_char,
    output logic [1:0]        o_status,
    output logic [LEN_W-1:0]  o_word_length,
    output logic              o_last
);

    logic              r_vld, n_vld;
    logic              r_le_pend, n_le_pend;
    t_kind             r_kind, n_kind;
    logic [CHAR_W-1:0] r_char, n_char;
    t_status           r_status, n_status;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_last, n_last;

    logic              load;

    // refill the output register when it is empty or being taken
    assign load = !r_vld || i_pop;

    always_comb begin
        n_vld     = r_vld;
        n_le_pend = r_le_pend;
        n_kind    = r_kind;
        n_char    = r_char;
        n_status  = r_status;
        n_len     = r_len;
        n_last    = r_last;
        o_q_pop   = 1'b0;
        if (load) begin
            if (r_le_pend) begin
                n_vld     = 1'b1;
                n_le_pend = 1'b0;
                n_kind    = KIND_LINE_END;
                n_char    = '0;
                n_status  = ST_OK;
                n_len     = '0;
                n_last    = 1'b1;
            end else if (!i_q_empty) begin
                n_vld     = 1'b1;
                n_le_pend = i_entry.line_end;
                n_kind    = i_entry.kind;
                n_char    = i_entry.word_char;
                n_status  = i_entry.status;
                n_len     = i_entry.word_length;
                n_last    = !i_entry.line_end;
                o_q_pop   = 1'b1;
            end else begin
                n_vld = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_le_pend <= 1'b0;
        end else begin
            r_vld     <= n_vld;
            r_le_pend <= n_le_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_char   <= n_char;
        r_status <= n_status;
        r_len    <= n_len;
        r_last   <= n_last;
    end

    assign o_empty       = !r_vld;
    assign o_kind        = r_kind;
    assign o_word_char   = r_char;
    assign o_status      = r_status;
    assign o_word_length = r_len;
    assign o_last        = r_last;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench
    import qwt_pkg::*;
();

    // Stall budget for the watchdog: cycles in a row with no transfer on either side.
    localparam int IDLE_LIMIT   = 3000;
    // Cycles to wait once every expected token has arrived.
    localparam int DRAIN_CYCLES = 20;
    // Least number of characters to push in all, the words at the length limit included.
    localparam int ITEM_COUNT   = 1800;
    // Receiver hold-off: after how many pushed characters it starts, and how long it lasts in cycles.
    localparam int HOLD_AFTER   = 600;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        t_kind             kind;
        logic [CHAR_W-1:0] ch;
        t_status           status;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_token;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              push = 1'b0;
    logic              full;
    logic [CHAR_W-1:0] i_character = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic [1:0]        o_kind;
    logic [CHAR_W-1:0] o_word_char;
    logic [1:0]        o_status;
    logic [LEN_W-1:0]  o_word_length;
    logic              o_last;

    quoted_word_tokenizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_character   (i_character),
        .empty         (empty),
        .pop           (pop),
        .o_kind        (o_kind),
        .o_word_char   (o_word_char),
        .o_status      (o_status),
        .o_word_length (o_word_length),
        .o_last        (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Characters waiting to be pushed, and tokens the splitter still owes us.
    logic [CHAR_W-1:0] pending_chars [$];
    t_token            expected_tokens [$];

    // Shadow copy of the splitter state.
    t_phase            scan_phase  = PH_BETWEEN;
    logic [CHAR_W-1:0] scan_delim  = CH_SPACE;
    bit                scan_escape = 1'b0;
    int                scan_count  = 0;

    int n_errors      = 0;
    int items_in      = 0;
    int results_out   = 0;
    int full_stalls   = 0;
    int long_items    = 0;
    int idle_cycles   = 0;
    int tx_gap        = 0;
    int rx_gap        = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int word_ends [4] = '{0, 0, 0, 0};

    function automatic t_token make_token(input t_kind k, input logic [CHAR_W-1:0] ch,
                                          input t_status st, input int len);
        t_token t;
        t.kind   = k;
        t.ch     = ch;
        t.status = st;
        t.len    = LEN_W'(len);
        t.last   = 1'b0;
        return t;
    endfunction

    // Advance the shadow state by one character and queue the tokens it yields.
    task automatic predict_tokens(input logic [CHAR_W-1:0] c);
        t_token  res [2];
        int      n;
        bit      err;
        t_status err_st;
        n      = 0;
        err    = 1'b0;
        err_st = ST_OK;
        case (scan_phase)
            PH_BETWEEN: begin
                if (c == CH_EOL) begin
                    res[n] = make_token(KIND_LINE_END, '0, ST_OK, 0);
                    n++;
                end else if (c == CH_SPACE) begin
                    // skip blanks between words
                end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                    // drop the opening quote, remember it as the closer
                    scan_delim  = c;
                    scan_count  = 0;
                    scan_escape = 1'b0;
                    scan_phase  = PH_WORD;
                end else begin
                    // bare word: first character is literal, even a backslash
                    scan_delim  = CH_SPACE;
                    scan_count  = 1;
                    scan_escape = 1'b0;
                    scan_phase  = PH_WORD;
                    res[n] = make_token(KIND_CHAR, c, ST_OK, scan_count);
                    n++;
                end
            end
            PH_WORD: begin
                if (scan_count >= MAX_WORD) begin
                    // at the limit only the closer is acceptable
                    scan_escape = 1'b0;
                    if (c == scan_delim) begin
                        res[n] = make_token(KIND_WORD_END, '0, ST_OK, scan_count);
                        n++;
                        scan_phase = PH_BETWEEN;
                    end else begin
                        err    = 1'b1;
                        err_st = ST_TOO_LONG;
                    end
                end else if (scan_escape) begin
                    scan_escape = 1'b0;
                    if (c == scan_delim || c == CH_BACKSLASH) begin
                        scan_count++;
                        res[n] = make_token(KIND_CHAR, c, ST_OK, scan_count);
                        n++;
                    end else begin
                        err    = 1'b1;
                        err_st = ST_BAD_ESCAPE;
                    end
                end else if (c == scan_delim) begin
                    res[n] = make_token(KIND_WORD_END, '0, ST_OK, scan_count);
                    n++;
                    scan_phase = PH_BETWEEN;
                end else if (c == CH_EOL) begin
                    // a bare word ends fine at end of line, a quoted one does not
                    res[n] = make_token(KIND_WORD_END, '0,
                                        (scan_delim == CH_SPACE) ? ST_OK : ST_UNTERMINATED,
                                        scan_count);
                    n++;
                    res[n] = make_token(KIND_LINE_END, '0, ST_OK, 0);
                    n++;
                    scan_phase = PH_BETWEEN;
                end else if (c == CH_BACKSLASH) begin
                    scan_escape = 1'b1;
                end else begin
                    scan_count++;
                    res[n] = make_token(KIND_CHAR, c, ST_OK, scan_count);
                    n++;
                end
            end
            default: begin
                // discarding the rest of a broken line
                if (c == CH_EOL) begin
                    res[n] = make_token(KIND_LINE_END, '0, ST_OK, 0);
                    n++;
                end
                scan_phase  = (c == CH_EOL) ? PH_BETWEEN : PH_DISCARD;
                scan_escape = 1'b0;
            end
        endcase
        if (err) begin
            res[n] = make_token(KIND_WORD_END, '0, err_st, scan_count);
            n++;
            if (c == CH_EOL) begin
                res[n] = make_token(KIND_LINE_END, '0, ST_OK, 0);
                n++;
                scan_phase = PH_BETWEEN;
            end else begin
                scan_phase = PH_DISCARD;
            end
        end
        for (int k = 0; k < n; k++) begin
            res[k].last = (k == n - 1);
            expected_tokens.push_back(res[k]);
        end
    endtask

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random word content that neither closes the word nor starts an escape.
    function automatic logic [CHAR_W-1:0] rand_word_char(input logic [CHAR_W-1:0] delim);
        logic [CHAR_W-1:0] c;
        do begin
            c = CHAR_W'($urandom_range(1, 255));
        end while (c == delim || c == CH_BACKSLASH || (c == CH_SPACE && delim == CH_SPACE));
        return c;
    endfunction

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++)
            pending_chars.push_back(CHAR_W'(s[k]));
        pending_chars.push_back(CH_EOL);
    endtask

    // Word filled to the length limit, followed by the given tail character.
    task automatic add_long_word(input logic [CHAR_W-1:0] delim,
                                 input logic [CHAR_W-1:0] tail);
        int start;
        start = pending_chars.size();
        if (delim == CH_SPACE)
            pending_chars.push_back(8'h77);
        else
            pending_chars.push_back(delim);
        for (int k = (delim == CH_SPACE) ? 1 : 0; k < MAX_WORD; k++)
            pending_chars.push_back(rand_word_char(delim));
        pending_chars.push_back(tail);
        if (tail != CH_EOL)
            pending_chars.push_back(CH_EOL);
        long_items += pending_chars.size() - start;
    endtask

    // One random line: mostly well-formed words with random content, some noise.
    task automatic add_random_line();
        int                nwords;
        int                len;
        int                r;
        logic [CHAR_W-1:0] delim;
        logic [CHAR_W-1:0] c;
        if ($urandom_range(0, 3) == 0) begin
            // noise: raw bytes biased toward the characters the parser cares about
            len = $urandom_range(1, 20);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 1) == 1) begin
                    c = CHAR_W'($urandom_range(0, 255));
                end else begin
                    case ($urandom_range(0, 4))
                        0: c = CH_SPACE;
                        1: c = CH_DQUOTE;
                        2: c = CH_SQUOTE;
                        3: c = CH_BACKSLASH;
                        default: c = CH_EOL;
                    endcase
                end
                pending_chars.push_back(c);
            end
            pending_chars.push_back(CH_EOL);
        end else begin
            repeat ($urandom_range(0, 2)) pending_chars.push_back(CH_SPACE);
            nwords = $urandom_range(1, 4);
            for (int w = 0; w < nwords; w++) begin
                r = $urandom_range(0, 2);
                delim = (r == 1) ? CH_DQUOTE : (r == 2) ? CH_SQUOTE : CH_SPACE;
                if (delim != CH_SPACE) begin
                    pending_chars.push_back(delim);
                end else begin
                    do begin
                        c = rand_word_char(CH_SPACE);
                    end while (c == CH_DQUOTE || c == CH_SQUOTE);
                    // now and then lead with a literal backslash
                    if ($urandom_range(0, 9) == 0)
                        c = CH_BACKSLASH;
                    pending_chars.push_back(c);
                end
                len = $urandom_range(0, 8);
                for (int k = 0; k < len; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 10) begin
                        pending_chars.push_back(CH_BACKSLASH);
                        pending_chars.push_back(($urandom_range(0, 1) == 1) ? delim
                                                                            : CH_BACKSLASH);
                    end else if (r < 12) begin
                        // invalid escape, possibly right before end of line
                        pending_chars.push_back(CH_BACKSLASH);
                        do begin
                            c = CHAR_W'($urandom_range(0, 255));
                        end while (c == delim || c == CH_BACKSLASH);
                        pending_chars.push_back(c);
                    end else begin
                        pending_chars.push_back(rand_word_char(delim));
                    end
                end
                // let the end of line close the final word once in a while
                if (!(w == nwords - 1 && $urandom_range(0, 3) == 0))
                    pending_chars.push_back(delim);
                if (w < nwords - 1)
                    repeat ($urandom_range(0, 2)) pending_chars.push_back(CH_SPACE);
            end
            pending_chars.push_back(CH_EOL);
        end
    endtask

    // Driver: offer the next pending character, hold it while full is high.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_tokens(i_character);
                items_in++;
            end
            if (push && full) begin
                // hold the offered character until the block takes it
                full_stalls++;
            end else if (tx_gap > 0) begin
                tx_gap--;
                push <= 1'b0;
            end else if (pending_chars.size() > 0) begin
                push        <= 1'b1;
                i_character <= pending_chars.pop_front();
                tx_gap       = pick_gap(((items_in / 200) % 4) == 2);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: check each transfer against the oldest expected token, then
    // decide whether to pop on the next cycle.
    always @(posedge i_clk) begin
        t_token exp_tok;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                results_out++;
                if (expected_tokens.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected token kind %0d char %0d status %0d len %0d last %0d",
                             $time, o_kind, o_word_char, o_status, o_word_length, o_last);
                end else begin
                    exp_tok = expected_tokens.pop_front();
                    if (o_kind == KIND_WORD_END)
                        word_ends[o_status]++;
                    if (o_kind !== exp_tok.kind || o_word_char !== exp_tok.ch ||
                        o_status !== exp_tok.status || o_word_length !== exp_tok.len ||
                        o_last !== exp_tok.last) begin
                        n_errors++;
                        $display({"%0t: mismatch expected kind %0d char %0d status %0d",
                                  " len %0d last %0d"},
                                 $time, exp_tok.kind, exp_tok.ch, exp_tok.status, exp_tok.len,
                                 exp_tok.last);
                        $display({"%0t:          actual   kind %0d char %0d status %0d",
                                  " len %0d last %0d"},
                                 $time, o_kind, o_word_char, o_status, o_word_length, o_last);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (!hold_done && items_in >= HOLD_AFTER) begin
                // stop draining for a long stretch so the input side backs up
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                pop      <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else begin
                pop    <= 1'b1;
                rx_gap  = pick_gap(((results_out / 150) % 3) == 1);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("quoted_word_tokenizer regression: fail");
            $finish;
        end
    end

    initial begin
        int line_no;
        i_rst_n = 1'b0;

        // Directed lines: empty line; bare word led by a backslash, then a
        // double-quoted word with escaped quote and backslash; invalid escape
        // and the discarded remainder; escape cut by end of line; unterminated
        // quote; extreme byte values in a bare word closed by end of line.
        add_text("");
        add_text("\\z \"\\\"\\\\\"");
        add_text("'a\\q b");
        add_text("x\\");
        add_text("'u");
        pending_chars.push_back(8'hFF);
        pending_chars.push_back(8'h01);
        pending_chars.push_back(CH_EOL);

        // Random lines, with the words driven to the length limit early on.
        line_no = 0;
        while (pending_chars.size() < ITEM_COUNT) begin
            case (line_no)
                0:  add_long_word(CH_SPACE, CH_SPACE);
                2:  add_long_word(CH_SPACE, CH_EOL);
                4:  add_long_word(CH_DQUOTE, CH_EOL);
                6:  add_long_word(CH_SQUOTE, CH_BACKSLASH);
                8:  add_long_word(CH_DQUOTE, CH_DQUOTE);
                default: ;
            endcase
            add_random_line();
            line_no++;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every character to transfer, then for every token.
        while (pending_chars.size() > 0 || push) @(posedge i_clk);
        while (expected_tokens.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d characters (%0d in limit-length words), %0d tokens",
                 items_in, long_items, results_out);
        $display("%0d full stalls; word ends seen: ok %0d, bad escape %0d, too long %0d, unterminated %0d",
                 full_stalls, word_ends[0], word_ends[1], word_ends[2], word_ends[3]);
        if (n_errors == 0) begin
            $display("quoted_word_tokenizer regression: pass");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("quoted_word_tokenizer regression: fail");
        end
        $finish;
    end

endmodule
